[src/sdi_pkg.sv]
// Package with the item types, codes and constants of the SD card init sequencer.
package sdi_pkg;

  // Host request codes.
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_RESP  = 2'd1;
  localparam logic [1:0] CMD_BLOCK = 2'd2;
  localparam logic [1:0] CMD_INFO  = 2'd3;

  // Expected response kinds.
  localparam logic [2:0] RK_NONE = 3'd0;
  localparam logic [2:0] RK_R1   = 3'd1;
  localparam logic [2:0] RK_R1B  = 3'd2;
  localparam logic [2:0] RK_R2   = 3'd3;
  localparam logic [2:0] RK_R3   = 3'd4;
  localparam logic [2:0] RK_R6   = 3'd5;
  localparam logic [2:0] RK_R7   = 3'd6;

  // Result status codes.
  localparam logic [2:0] ST_BUSY   = 3'd0;
  localparam logic [2:0] ST_DONE   = 3'd1;
  localparam logic [2:0] ST_IFCOND = 3'd2;
  localparam logic [2:0] ST_NO33   = 3'd3;
  localparam logic [2:0] ST_APP    = 3'd4;
  localparam logic [2:0] ST_BLOCK  = 3'd5;
  localparam logic [2:0] ST_INFO   = 3'd6;

  // Card kinds.
  localparam logic [1:0] CK_LEGACY = 2'd0;
  localparam logic [1:0] CK_V2_SC  = 2'd1;
  localparam logic [1:0] CK_HC     = 2'd2;

  // SD command numbers.
  localparam logic [5:0] SD_CMD0   = 6'd0;
  localparam logic [5:0] SD_CMD2   = 6'd2;
  localparam logic [5:0] SD_CMD3   = 6'd3;
  localparam logic [5:0] SD_ACMD6  = 6'd6;
  localparam logic [5:0] SD_CMD7   = 6'd7;
  localparam logic [5:0] SD_CMD8   = 6'd8;
  localparam logic [5:0] SD_CMD9   = 6'd9;
  localparam logic [5:0] SD_CMD13  = 6'd13;
  localparam logic [5:0] SD_CMD16  = 6'd16;
  localparam logic [5:0] SD_CMD17  = 6'd17;
  localparam logic [5:0] SD_CMD24  = 6'd24;
  localparam logic [5:0] SD_ACMD41 = 6'd41;
  localparam logic [5:0] SD_CMD55  = 6'd55;

  // Response bits and command arguments.
  localparam int unsigned APP_CMD_POS   = 5;
  localparam int unsigned OCR_3V3_POS   = 20;
  localparam int unsigned OCR_CCS_POS   = 30;
  localparam int unsigned OCR_READY_POS = 31;
  localparam logic [31:0] IFCOND_ARG    = 32'h0000_01AA;
  localparam logic [31:0] OCR_3V3_ARG   = 32'h0010_0000;
  localparam logic [31:0] OCR_CCS_ARG   = 32'h4000_0000;
  localparam logic [31:0] BLOCK_BYTES   = 32'd512;
  localparam logic [31:0] BUS_4BIT_ARG  = 32'd2;
  localparam logic [3:0]  STATE_TRAN    = 4'd4;
  localparam int unsigned BLOCK_SHIFT   = 9;

  typedef struct packed {
    logic [1:0]  command;
    logic        resp_timeout;
    logic        resp_error;
    logic [31:0] resp_word0;
    logic [31:0] resp_word1;
    logic [31:0] resp_word2;
    logic [31:0] resp_word3;
    logic [31:0] block_number;
    logic        write_access;
    logic [2:0]  info_index;
  } req_item_t;

  typedef struct packed {
    logic        cmd_valid;
    logic [5:0]  cmd_index;
    logic [31:0] cmd_arg;
    logic [2:0]  resp_kind;
    logic [2:0]  status;
    logic [1:0]  card_kind;
    logic [15:0] card_address;
    logic        fast_clock;
    logic [31:0] info_word;
  } rsp_item_t;

endpackage

[src/sdi_if.sv]
// Valid/ready channel interfaces for the request and result items.
interface sdi_req_if;
  logic                 valid;
  logic                 ready;
  sdi_pkg::req_item_t   data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sdi_rsp_if;
  logic                 valid;
  logic                 ready;
  sdi_pkg::rsp_item_t   data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/sd_card_init_sequencer_core.sv]
// SD card bring-up and single-block command sequencer, top level.
//
// The sequencer takes one request item per cycle on req (start, card
// response, block request or info read) and answers each with exactly one
// result item on rsp: the next SD command to send (index, argument and
// expected response kind) or a final status, together with the current card
// kind, relative card address and fast-clock flag. The decision for an item
// is made in the cycle it is accepted and lands in a single result register,
// so results appear in the cycle after acceptance and a new item is taken every
// cycle as long as the result register is empty or being drained in the same
// cycle; a stall on rsp backs up onto req after one item. There is no
// clearing pass after reset: all state resets at once.
module sd_card_init_sequencer_core (
  input  logic     clk,
  input  logic     rst,
  sdi_req_if.sink  req,
  sdi_rsp_if.source rsp
);

  // Sequencer phases; apart from idle and ready, each names the command whose response is awaited.
  typedef enum logic [4:0] {
    PH_IDLE, PH_CMD0, PH_CMD8, PH_V55, PH_VOP, PH_R55, PH_ROP, PH_CID,
    PH_RCA, PH_CSD, PH_SEL, PH_B55, PH_BW, PH_BLEN, PH_READY, PH_POLL,
    PH_XFER
  } phase_t;

  phase_t      phase, phase_next;
  logic [1:0]  kind_reg, kind_next;
  logic [15:0] address_reg, address_next;
  logic        clock_fast_reg, clock_fast_next;
  logic [31:0] pending_block_arg, pending_block_arg_next;
  logic        pending_write, pending_write_next;
  logic [31:0] identity_store [4];
  logic [31:0] specific_store [4];
  logic        identity_wr, specific_wr;

  logic                out_valid;
  sdi_pkg::rsp_item_t  out_item;
  sdi_pkg::rsp_item_t  res;
  logic                accept;

  // The result register is free when empty or being taken this cycle.
  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_item;

  // Decide the next command or status for the presented item.
  always_comb begin
    logic        tmo;
    logic        err;
    logic [31:0] w0;
    logic        app_ok;
    logic [31:0] rca;
    logic [31:0] op_arg;

    tmo    = req.data.resp_timeout;
    err    = req.data.resp_error;
    w0     = req.data.resp_word0;
    app_ok = !tmo && !err && w0[sdi_pkg::APP_CMD_POS];

    phase_next             = phase;
    kind_next              = kind_reg;
    address_next           = address_reg;
    clock_fast_next        = clock_fast_reg;
    pending_block_arg_next = pending_block_arg;
    pending_write_next     = pending_write;
    identity_wr            = 1'b0;
    specific_wr            = 1'b0;

    res           = '0;
    res.status    = sdi_pkg::ST_BUSY;
    res.resp_kind = sdi_pkg::RK_NONE;

    // The card address is captured from the CMD3 response before use.
    if (req.data.command == sdi_pkg::CMD_RESP && phase == PH_RCA) begin
      address_next = w0[31:16];
    end
    rca    = {address_next, 16'h0000};
    op_arg = sdi_pkg::OCR_3V3_ARG;
    if (kind_reg == sdi_pkg::CK_V2_SC) begin
      op_arg = op_arg | sdi_pkg::OCR_CCS_ARG;
    end

    unique case (req.data.command)
      sdi_pkg::CMD_START: begin
        clock_fast_next = 1'b0;
        phase_next      = PH_CMD0;
        res.cmd_valid   = 1'b1;
        res.cmd_index   = sdi_pkg::SD_CMD0;
      end
      sdi_pkg::CMD_RESP: begin
        unique case (phase)
          PH_CMD0: begin
            phase_next    = PH_CMD8;
            res.cmd_valid = 1'b1;
            res.cmd_index = sdi_pkg::SD_CMD8;
            res.cmd_arg   = sdi_pkg::IFCOND_ARG;
            res.resp_kind = sdi_pkg::RK_R7;
          end
          PH_CMD8: begin
            if (err && !tmo) begin
              phase_next = PH_IDLE;
              res.status = sdi_pkg::ST_IFCOND;
            end else begin
              kind_next     = tmo ? sdi_pkg::CK_LEGACY : sdi_pkg::CK_V2_SC;
              phase_next    = PH_V55;
              res.cmd_valid = 1'b1;
              res.cmd_index = sdi_pkg::SD_CMD55;
              res.resp_kind = sdi_pkg::RK_R1;
            end
          end
          PH_V55: begin
            if (app_ok) begin
              phase_next    = PH_VOP;
              res.cmd_valid = 1'b1;
              res.cmd_index = sdi_pkg::SD_ACMD41;
              res.resp_kind = sdi_pkg::RK_R3;
            end else begin
              phase_next = PH_IDLE;
              res.status = sdi_pkg::ST_APP;
            end
          end
          PH_VOP: begin
            if (!w0[sdi_pkg::OCR_3V3_POS]) begin
              phase_next = PH_IDLE;
              res.status = sdi_pkg::ST_NO33;
            end else begin
              phase_next    = PH_R55;
              res.cmd_valid = 1'b1;
              res.cmd_index = sdi_pkg::SD_CMD55;
              res.resp_kind = sdi_pkg::RK_R1;
            end
          end
          PH_R55: begin
            res.cmd_valid = 1'b1;
            if (app_ok) begin
              phase_next    = PH_ROP;
              res.cmd_index = sdi_pkg::SD_ACMD41;
              res.cmd_arg   = op_arg;
              res.resp_kind = sdi_pkg::RK_R3;
            end else begin
              res.cmd_index = sdi_pkg::SD_CMD55;
              res.resp_kind = sdi_pkg::RK_R1;
            end
          end
          PH_ROP: begin
            res.cmd_valid = 1'b1;
            if (!w0[sdi_pkg::OCR_READY_POS]) begin
              phase_next    = PH_R55;
              res.cmd_index = sdi_pkg::SD_CMD55;
              res.resp_kind = sdi_pkg::RK_R1;
            end else begin
              if (kind_reg == sdi_pkg::CK_V2_SC && w0[sdi_pkg::OCR_CCS_POS]) begin
                kind_next = sdi_pkg::CK_HC;
              end
              phase_next    = PH_CID;
              res.cmd_index = sdi_pkg::SD_CMD2;
              res.resp_kind = sdi_pkg::RK_R2;
            end
          end
          PH_CID: begin
            identity_wr   = 1'b1;
            phase_next    = PH_RCA;
            res.cmd_valid = 1'b1;
            res.cmd_index = sdi_pkg::SD_CMD3;
            res.resp_kind = sdi_pkg::RK_R6;
          end
          PH_RCA: begin
            phase_next    = PH_CSD;
            res.cmd_valid = 1'b1;
            res.cmd_index = sdi_pkg::SD_CMD9;
            res.cmd_arg   = rca;
            res.resp_kind = sdi_pkg::RK_R2;
          end
          PH_CSD: begin
            specific_wr   = 1'b1;
            phase_next    = PH_SEL;
            res.cmd_valid = 1'b1;
            res.cmd_index = sdi_pkg::SD_CMD7;
            res.cmd_arg   = rca;
            res.resp_kind = sdi_pkg::RK_R1B;
          end
          PH_SEL: begin
            phase_next    = PH_B55;
            res.cmd_valid = 1'b1;
            res.cmd_index = sdi_pkg::SD_CMD55;
            res.cmd_arg   = rca;
            res.resp_kind = sdi_pkg::RK_R1;
          end
          PH_B55: begin
            res.cmd_valid = 1'b1;
            res.resp_kind = sdi_pkg::RK_R1;
            if (app_ok) begin
              phase_next    = PH_BW;
              res.cmd_index = sdi_pkg::SD_ACMD6;
              res.cmd_arg   = sdi_pkg::BUS_4BIT_ARG;
            end else begin
              // The bus width change is skipped when APP_CMD is refused.
              clock_fast_next = 1'b1;
              phase_next      = PH_BLEN;
              res.cmd_index   = sdi_pkg::SD_CMD16;
              res.cmd_arg     = sdi_pkg::BLOCK_BYTES;
            end
          end
          PH_BW: begin
            clock_fast_next = 1'b1;
            phase_next      = PH_BLEN;
            res.cmd_valid   = 1'b1;
            res.cmd_index   = sdi_pkg::SD_CMD16;
            res.cmd_arg     = sdi_pkg::BLOCK_BYTES;
            res.resp_kind   = sdi_pkg::RK_R1;
          end
          PH_BLEN: begin
            phase_next = PH_READY;
            res.status = sdi_pkg::ST_DONE;
          end
          PH_POLL: begin
            res.cmd_valid = 1'b1;
            res.resp_kind = sdi_pkg::RK_R1;
            if (w0[12:9] != sdi_pkg::STATE_TRAN) begin
              res.cmd_index = sdi_pkg::SD_CMD13;
              res.cmd_arg   = rca;
            end else begin
              phase_next    = PH_XFER;
              res.cmd_index = pending_write ? sdi_pkg::SD_CMD24 : sdi_pkg::SD_CMD17;
              res.cmd_arg   = pending_block_arg;
            end
          end
          PH_XFER: begin
            phase_next = PH_READY;
            res.status = sdi_pkg::ST_BLOCK;
          end
          default: begin
            // No response is awaited in idle or ready; the item is dropped.
          end
        endcase
      end
      sdi_pkg::CMD_BLOCK: begin
        if (phase == PH_READY) begin
          if (kind_reg == sdi_pkg::CK_HC) begin
            pending_block_arg_next = req.data.block_number;
          end else begin
            pending_block_arg_next = req.data.block_number << sdi_pkg::BLOCK_SHIFT;
          end
          pending_write_next = req.data.write_access;
          phase_next         = PH_POLL;
          res.cmd_valid      = 1'b1;
          res.cmd_index      = sdi_pkg::SD_CMD13;
          res.cmd_arg        = rca;
          res.resp_kind      = sdi_pkg::RK_R1;
        end
      end
      sdi_pkg::CMD_INFO: begin
        res.status = sdi_pkg::ST_INFO;
        if (req.data.info_index[2]) begin
          res.info_word = specific_store[req.data.info_index[1:0]];
        end else begin
          res.info_word = identity_store[req.data.info_index[1:0]];
        end
      end
      default: begin
      end
    endcase

    res.card_kind    = kind_next;
    res.card_address = address_next;
    res.fast_clock   = clock_fast_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      kind_reg          <= sdi_pkg::CK_LEGACY;
      address_reg       <= '0;
      clock_fast_reg    <= 1'b0;
      pending_block_arg <= '0;
      pending_write     <= 1'b0;
      identity_store    <= '{default: '0};
      specific_store    <= '{default: '0};
      out_valid         <= 1'b0;
    end else begin
      if (accept) begin
        phase             <= phase_next;
        kind_reg          <= kind_next;
        address_reg       <= address_next;
        clock_fast_reg    <= clock_fast_next;
        pending_block_arg <= pending_block_arg_next;
        pending_write     <= pending_write_next;
        if (identity_wr) begin
          identity_store[0] <= req.data.resp_word0;
          identity_store[1] <= req.data.resp_word1;
          identity_store[2] <= req.data.resp_word2;
          identity_store[3] <= req.data.resp_word3;
        end
        if (specific_wr) begin
          specific_store[0] <= req.data.resp_word0;
          specific_store[1] <= req.data.resp_word1;
          specific_store[2] <= req.data.resp_word2;
          specific_store[3] <= req.data.resp_word3;
        end
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_item <= res;
    end
  end

`ifndef SYNTHESIS
  // A status result never carries a command, and an idle command slot is all zero.
  a_status_no_cmd: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.status != sdi_pkg::ST_BUSY) |-> !out_item.cmd_valid)
    else $error("status result carries a command");

  a_empty_cmd_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_item.cmd_valid) |->
      (out_item.cmd_index == '0 && out_item.cmd_arg == '0
       && out_item.resp_kind == sdi_pkg::RK_NONE))
    else $error("command fields set without a command");

  // Bring-up only completes after the clock switch.
  a_done_fast: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.status == sdi_pkg::ST_DONE) |-> out_item.fast_clock)
    else $error("init done without fast clock");

  // A start always restarts bring-up from CMD0.
  a_start_restarts: assert property (@(posedge clk) disable iff (rst)
    (accept && req.data.command == sdi_pkg::CMD_START) |=>
      (phase == PH_CMD0 && !clock_fast_reg))
    else $error("start did not restart bring-up");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    kind_reg <= sdi_pkg::CK_HC)
    else $error("card kind out of range");
`endif

endmodule

[verif/sd_card_init_sequencer_core_tb.sv]
// Self-checking testbench for the SD card init sequencer with scripted card responses.
`timescale 1ns / 100ps

module sd_card_init_sequencer_core_tb;

  // Sequencer position as the testbench tracks it. It moves in step with the
  // block on every accepted request item.
  typedef enum logic [4:0] {
    SEQ_IDLE, SEQ_CMD0, SEQ_IFCOND, SEQ_VOLT_APP, SEQ_VOLT_OP, SEQ_READY_APP,
    SEQ_READY_OP, SEQ_CID, SEQ_RCA, SEQ_CSD, SEQ_SELECT, SEQ_BUS_APP,
    SEQ_BUS_WIDTH, SEQ_BLOCK_LEN, SEQ_READY, SEQ_POLL, SEQ_XFER
  } seq_phase_t;

  // How the card answers the interface condition command.
  typedef enum int {IFC_LEGACY, IFC_V2, IFC_BROKEN} ifcond_t;

  // Fill pattern for response words that the sequence does not constrain.
  typedef enum int {WS_RANDOM, WS_ONES, WS_ZEROS} word_style_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sdi_req_if req_ch ();
  sdi_rsp_if rsp_ch ();

  sd_card_init_sequencer_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predicted sequencer state.
  seq_phase_t  ph_now        = SEQ_IDLE;
  logic [1:0]  kind_now      = sdi_pkg::CK_LEGACY;
  logic [15:0] rca_now       = '0;
  logic [31:0] cid_words [4] = '{default: '0};
  logic [31:0] csd_words [4] = '{default: '0};
  logic [31:0] blk_arg_now   = '0;
  logic        blk_write_now = 1'b0;
  logic        fast_now      = 1'b0;

  // Request items waiting to be driven, and results owed by the block.
  sdi_pkg::req_item_t host_req_q [$];
  sdi_pkg::rsp_item_t cmd_expect_q [$];

  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          err_count   = 0;
  int          live_count  = 0;
  int          abort_pct   = 0;
  bit          noise_on    = 1'b0;
  bit          ready_now   = 1'b0;
  bit          req_taken   = 1'b0;
  word_style_t word_style  = WS_RANDOM;

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  // Argument that carries the relative card address in its upper half.
  function automatic logic [31:0] rca_word();
    return {rca_now, 16'h0000};
  endfunction

  function automatic sdi_pkg::rsp_item_t make_cmd(logic [5:0] idx, logic [31:0] arg,
                                                  logic [2:0] rk);
    sdi_pkg::rsp_item_t r;
    r = '0;
    r.cmd_valid = 1'b1;
    r.cmd_index = idx;
    r.cmd_arg   = arg;
    r.resp_kind = rk;
    r.status    = sdi_pkg::ST_BUSY;
    return r;
  endfunction

  // Works out the one result item the block owes for a request item and
  // advances the predicted state.
  function automatic sdi_pkg::rsp_item_t predict_card_step(sdi_pkg::req_item_t it);
    sdi_pkg::rsp_item_t r;
    logic        app_ok;
    logic [31:0] w0;
    logic [31:0] op_arg;
    r = '0;
    w0 = it.resp_word0;
    // An APP_CMD acknowledge needs a clean answer with the APP_CMD bit set.
    app_ok = !it.resp_timeout && !it.resp_error && w0[sdi_pkg::APP_CMD_POS];
    case (it.command)
      sdi_pkg::CMD_START: begin
        // A start is honored anywhere and drops back to the slow clock.
        fast_now = 1'b0;
        ph_now = SEQ_CMD0;
        r = make_cmd(sdi_pkg::SD_CMD0, '0, sdi_pkg::RK_NONE);
      end
      sdi_pkg::CMD_RESP: begin
        case (ph_now)
          SEQ_CMD0: begin
            ph_now = SEQ_IFCOND;
            r = make_cmd(sdi_pkg::SD_CMD8, sdi_pkg::IFCOND_ARG, sdi_pkg::RK_R7);
          end
          SEQ_IFCOND: begin
            // No answer means a legacy card; a bad answer aborts bring-up.
            if (it.resp_timeout || !it.resp_error) begin
              kind_now = it.resp_timeout ? sdi_pkg::CK_LEGACY : sdi_pkg::CK_V2_SC;
              ph_now = SEQ_VOLT_APP;
              r = make_cmd(sdi_pkg::SD_CMD55, '0, sdi_pkg::RK_R1);
            end else begin
              ph_now = SEQ_IDLE;
              r.status = sdi_pkg::ST_IFCOND;
            end
          end
          SEQ_VOLT_APP: begin
            if (app_ok) begin
              ph_now = SEQ_VOLT_OP;
              r = make_cmd(sdi_pkg::SD_ACMD41, '0, sdi_pkg::RK_R3);
            end else begin
              ph_now = SEQ_IDLE;
              r.status = sdi_pkg::ST_APP;
            end
          end
          SEQ_VOLT_OP: begin
            if (!w0[sdi_pkg::OCR_3V3_POS]) begin
              ph_now = SEQ_IDLE;
              r.status = sdi_pkg::ST_NO33;
            end else begin
              ph_now = SEQ_READY_APP;
              r = make_cmd(sdi_pkg::SD_CMD55, '0, sdi_pkg::RK_R1);
            end
          end
          SEQ_READY_APP: begin
            // In the power-up loop a failed CMD55 is simply sent again.
            if (app_ok) begin
              op_arg = sdi_pkg::OCR_3V3_ARG;
              if (kind_now == sdi_pkg::CK_V2_SC) begin
                op_arg = op_arg | sdi_pkg::OCR_CCS_ARG;
              end
              ph_now = SEQ_READY_OP;
              r = make_cmd(sdi_pkg::SD_ACMD41, op_arg, sdi_pkg::RK_R3);
            end else begin
              r = make_cmd(sdi_pkg::SD_CMD55, '0, sdi_pkg::RK_R1);
            end
          end
          SEQ_READY_OP: begin
            if (!w0[sdi_pkg::OCR_READY_POS]) begin
              ph_now = SEQ_READY_APP;
              r = make_cmd(sdi_pkg::SD_CMD55, '0, sdi_pkg::RK_R1);
            end else begin
              if (kind_now == sdi_pkg::CK_V2_SC && w0[sdi_pkg::OCR_CCS_POS]) begin
                kind_now = sdi_pkg::CK_HC;
              end
              ph_now = SEQ_CID;
              r = make_cmd(sdi_pkg::SD_CMD2, '0, sdi_pkg::RK_R2);
            end
          end
          SEQ_CID: begin
            cid_words[0] = it.resp_word0;
            cid_words[1] = it.resp_word1;
            cid_words[2] = it.resp_word2;
            cid_words[3] = it.resp_word3;
            ph_now = SEQ_RCA;
            r = make_cmd(sdi_pkg::SD_CMD3, '0, sdi_pkg::RK_R6);
          end
          SEQ_RCA: begin
            rca_now = w0[31:16];
            ph_now = SEQ_CSD;
            r = make_cmd(sdi_pkg::SD_CMD9, rca_word(), sdi_pkg::RK_R2);
          end
          SEQ_CSD: begin
            csd_words[0] = it.resp_word0;
            csd_words[1] = it.resp_word1;
            csd_words[2] = it.resp_word2;
            csd_words[3] = it.resp_word3;
            ph_now = SEQ_SELECT;
            r = make_cmd(sdi_pkg::SD_CMD7, rca_word(), sdi_pkg::RK_R1B);
          end
          SEQ_SELECT: begin
            ph_now = SEQ_BUS_APP;
            r = make_cmd(sdi_pkg::SD_CMD55, rca_word(), sdi_pkg::RK_R1);
          end
          SEQ_BUS_APP: begin
            // Without an APP_CMD acknowledge the bus width step is skipped.
            if (app_ok) begin
              ph_now = SEQ_BUS_WIDTH;
              r = make_cmd(sdi_pkg::SD_ACMD6, sdi_pkg::BUS_4BIT_ARG, sdi_pkg::RK_R1);
            end else begin
              fast_now = 1'b1;
              ph_now = SEQ_BLOCK_LEN;
              r = make_cmd(sdi_pkg::SD_CMD16, sdi_pkg::BLOCK_BYTES, sdi_pkg::RK_R1);
            end
          end
          SEQ_BUS_WIDTH: begin
            fast_now = 1'b1;
            ph_now = SEQ_BLOCK_LEN;
            r = make_cmd(sdi_pkg::SD_CMD16, sdi_pkg::BLOCK_BYTES, sdi_pkg::RK_R1);
          end
          SEQ_BLOCK_LEN: begin
            ph_now = SEQ_READY;
            r.status = sdi_pkg::ST_DONE;
          end
          SEQ_POLL: begin
            if (w0[12:9] != sdi_pkg::STATE_TRAN) begin
              r = make_cmd(sdi_pkg::SD_CMD13, rca_word(), sdi_pkg::RK_R1);
            end else begin
              ph_now = SEQ_XFER;
              r = make_cmd(blk_write_now ? sdi_pkg::SD_CMD24 : sdi_pkg::SD_CMD17,
                           blk_arg_now, sdi_pkg::RK_R1);
            end
          end
          SEQ_XFER: begin
            ph_now = SEQ_READY;
            r.status = sdi_pkg::ST_BLOCK;
          end
          default: begin
            // No response is awaited here, so the item is dropped.
          end
        endcase
      end
      sdi_pkg::CMD_BLOCK: begin
        if (ph_now == SEQ_READY) begin
          // Standard capacity cards take a byte address, wrapping at 32 bits.
          blk_arg_now = (kind_now == sdi_pkg::CK_HC) ? it.block_number
                        : it.block_number << sdi_pkg::BLOCK_SHIFT;
          blk_write_now = it.write_access;
          ph_now = SEQ_POLL;
          r = make_cmd(sdi_pkg::SD_CMD13, rca_word(), sdi_pkg::RK_R1);
        end
      end
      default: begin
        r.info_word = it.info_index[2] ? csd_words[it.info_index[1:0]]
                                       : cid_words[it.info_index[1:0]];
        r.status = sdi_pkg::ST_INFO;
      end
    endcase
    r.card_kind    = kind_now;
    r.card_address = rca_now;
    r.fast_clock   = fast_now;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------

  // Prints one line per mismatch and counts it.
  task automatic flag_error(string msg);
    $display("tb: mismatch: %s", msg);
    err_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      flag_error($sformatf("%s got %h want %h", name, got, want));
    end
  endtask

  // Both channels are sampled at the rising edge; the prediction for an
  // accepted request is queued before the result side is checked.
  always @(posedge clk) begin : sample_edge
    sdi_pkg::rsp_item_t want;
    sdi_pkg::rsp_item_t got;
    req_taken = 1'b0;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        req_taken = 1'b1;
        cmd_expect_q.push_back(predict_card_step(req_ch.data));
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = rsp_ch.data;
        if (cmd_expect_q.size() == 0) begin
          flag_error("result item with no request waiting");
        end else begin
          want = cmd_expect_q.pop_front();
          check_field("cmd_valid", 32'(got.cmd_valid), 32'(want.cmd_valid));
          check_field("cmd_index", 32'(got.cmd_index), 32'(want.cmd_index));
          check_field("cmd_arg", got.cmd_arg, want.cmd_arg);
          check_field("resp_kind", 32'(got.resp_kind), 32'(want.resp_kind));
          check_field("status", 32'(got.status), 32'(want.status));
          check_field("card_kind", 32'(got.card_kind), 32'(want.card_kind));
          check_field("card_address", 32'(got.card_address), 32'(want.card_address));
          check_field("fast_clock", 32'(got.fast_clock), 32'(want.fast_clock));
          check_field("info_word", got.info_word, want.info_word);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------

  // Inputs move at the falling edge. A request item is held until taken;
  // each signal gets a single nonblocking update per edge.
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_taken) begin
      if (host_req_q.size() != 0 && $urandom_range(99, 0) >= tx_idle_pct) begin
        req_ch.data  <= host_req_q.pop_front();
        req_ch.valid <= 1'b1;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
    rsp_ch.ready <= !rst && ($urandom_range(99, 0) >= rx_idle_pct);
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  function automatic logic [31:0] pick_word();
    case (word_style)
      WS_ONES:  return '1;
      WS_ZEROS: return '0;
      default:  return $urandom();
    endcase
  endfunction

  // A request of the given kind with every other field random, the response words following the word style.
  function automatic sdi_pkg::req_item_t rand_req(logic [1:0] cmd);
    sdi_pkg::req_item_t it;
    it.command      = cmd;
    it.resp_timeout = 1'($urandom_range(1, 0));
    it.resp_error   = 1'($urandom_range(1, 0));
    it.resp_word0   = pick_word();
    it.resp_word1   = pick_word();
    it.resp_word2   = pick_word();
    it.resp_word3   = pick_word();
    it.block_number = $urandom();
    it.write_access = 1'($urandom_range(1, 0));
    it.info_index   = 3'($urandom_range(7, 0));
    return it;
  endfunction

  function automatic sdi_pkg::req_item_t info_req(logic [2:0] idx);
    sdi_pkg::req_item_t it;
    it = rand_req(sdi_pkg::CMD_INFO);
    it.info_index = idx;
    return it;
  endfunction

  // Card answer to CMD55: a clean acknowledge, or one of the ways it fails.
  function automatic sdi_pkg::req_item_t app_resp(bit good);
    sdi_pkg::req_item_t it;
    it = rand_req(sdi_pkg::CMD_RESP);
    it.resp_timeout = 1'b0;
    it.resp_error   = 1'b0;
    it.resp_word0[sdi_pkg::APP_CMD_POS] = good;
    if (!good) begin
      case ($urandom_range(2, 0))
        0: it.resp_timeout = 1'b1;
        1: it.resp_error = 1'b1;
        default: ;
      endcase
      if ($urandom_range(1, 0) == 0) begin
        it.resp_word0[sdi_pkg::APP_CMD_POS] = 1'b1;
      end
      if (!it.resp_timeout && !it.resp_error) begin
        it.resp_word0[sdi_pkg::APP_CMD_POS] = 1'b0;
      end
    end
    return it;
  endfunction

  // Card current state field with any value but transfer.
  function automatic logic [3:0] not_tran();
    logic [3:0] v;
    v = 4'($urandom_range(14, 0));
    if (v >= sdi_pkg::STATE_TRAN) begin
      v = v + 4'd1;
    end
    return v;
  endfunction

  task automatic send(sdi_pkg::req_item_t it, bit live);
    host_req_q.push_back(it);
    if (live) begin
      live_count++;
    end
  endtask

  // Sends a card response, now and then preceded by an info read or by a
  // block request that the block must ignore at this point.
  task automatic answer(sdi_pkg::req_item_t it);
    int r;
    r = $urandom_range(99, 0);
    if (noise_on && r < 8) begin
      send(info_req(3'($urandom_range(7, 0))), 1'b1);
    end else if (noise_on && r < 11) begin
      send(rand_req(sdi_pkg::CMD_BLOCK), 1'b0);
    end
    send(it, 1'b1);
  endtask

  // One bring-up attempt, from the start item to CMD16 or an early exit.
  task automatic bring_up(ifcond_t ifc, bit volt_app_ok, bit has33, int retries,
                          bit ccs, bit bus_ok, output bit ok);
    sdi_pkg::req_item_t it;
    ok = 1'b0;
    send(rand_req(sdi_pkg::CMD_START), 1'b1);
    answer(rand_req(sdi_pkg::CMD_RESP));
    it = rand_req(sdi_pkg::CMD_RESP);
    case (ifc)
      IFC_LEGACY: it.resp_timeout = 1'b1;
      IFC_V2: begin
        it.resp_timeout = 1'b0;
        it.resp_error = 1'b0;
      end
      default: begin
        it.resp_timeout = 1'b0;
        it.resp_error = 1'b1;
      end
    endcase
    answer(it);
    if (ifc == IFC_BROKEN) begin
      return;
    end
    answer(app_resp(volt_app_ok));
    if (!volt_app_ok) begin
      return;
    end
    it = rand_req(sdi_pkg::CMD_RESP);
    it.resp_word0[sdi_pkg::OCR_3V3_POS] = has33;
    answer(it);
    if (!has33 || $urandom_range(99, 0) < abort_pct) begin
      return;
    end
    // Busy loop: either the CMD55 fails or the card still reports busy.
    repeat (retries) begin
      if ($urandom_range(1, 0) == 0) begin
        answer(app_resp(1'b0));
      end else begin
        answer(app_resp(1'b1));
        it = rand_req(sdi_pkg::CMD_RESP);
        it.resp_word0[sdi_pkg::OCR_READY_POS] = 1'b0;
        answer(it);
      end
    end
    answer(app_resp(1'b1));
    it = rand_req(sdi_pkg::CMD_RESP);
    it.resp_word0[sdi_pkg::OCR_READY_POS] = 1'b1;
    it.resp_word0[sdi_pkg::OCR_CCS_POS] = ccs;
    answer(it);
    answer(rand_req(sdi_pkg::CMD_RESP));
    if ($urandom_range(99, 0) < abort_pct) begin
      return;
    end
    answer(rand_req(sdi_pkg::CMD_RESP));
    answer(rand_req(sdi_pkg::CMD_RESP));
    answer(rand_req(sdi_pkg::CMD_RESP));
    answer(app_resp(bus_ok));
    if (bus_ok) begin
      answer(rand_req(sdi_pkg::CMD_RESP));
    end
    answer(rand_req(sdi_pkg::CMD_RESP));
    ok = 1'b1;
  endtask

  // One block access from a ready card: request, status polls, transfer.
  task automatic block_access(logic [31:0] blk, bit wr, int polls);
    sdi_pkg::req_item_t it;
    if (noise_on && $urandom_range(99, 0) < 5) begin
      send(rand_req(sdi_pkg::CMD_RESP), 1'b0);
    end
    it = rand_req(sdi_pkg::CMD_BLOCK);
    it.block_number = blk;
    it.write_access = wr;
    send(it, 1'b1);
    repeat (polls) begin
      it = rand_req(sdi_pkg::CMD_RESP);
      it.resp_word0[12:9] = not_tran();
      answer(it);
    end
    it = rand_req(sdi_pkg::CMD_RESP);
    it.resp_word0[12:9] = sdi_pkg::STATE_TRAN;
    answer(it);
    answer(rand_req(sdi_pkg::CMD_RESP));
  endtask

  // Fills the queue with random scenarios until the item count is reached.
  task automatic random_phase(int stop_at);
    int  r;
    bit  ok;
    ifcond_t ifc;
    logic [31:0] blk;
    while (live_count < stop_at) begin
      r = $urandom_range(99, 0);
      if (r < 8) begin
        // Broken traffic: arbitrary items, after which bring-up starts over.
        repeat ($urandom_range(4, 1)) begin
          send(rand_req(2'($urandom_range(3, 0))), 1'b1);
        end
        ready_now = 1'b0;
      end else if (ready_now && r < 60) begin
        repeat ($urandom_range(3, 1)) begin
          case ($urandom_range(9, 0))
            0: blk = '0;
            1: blk = '1;
            default: blk = $urandom();
          endcase
          block_access(blk, 1'($urandom_range(1, 0)), int'($urandom_range(3, 0)));
        end
      end else begin
        r = $urandom_range(99, 0);
        ifc = (r < 10) ? IFC_BROKEN : (r < 40) ? IFC_LEGACY : IFC_V2;
        bring_up(ifc, $urandom_range(99, 0) < 90, $urandom_range(99, 0) < 90,
                 int'($urandom_range(3, 0)), 1'($urandom_range(1, 0)),
                 $urandom_range(99, 0) < 80, ok);
        ready_now = ok;
      end
    end
  endtask

  // The sender holds off until every request has been taken and answered.
  task automatic drain_all();
    while (host_req_q.size() != 0 || req_ch.valid || cmd_expect_q.size() != 0) begin
      @(negedge clk);
    end
  endtask

  initial begin : stimulus
    bit ok;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    rsp_ch.ready = 1'b0;
    tx_idle_pct  = 35;
    rx_idle_pct  = 45;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part. Nothing is awaited yet, so a response and a block
    // request are both dropped; the stores still read as zero.
    word_style = WS_ZEROS;
    send(rand_req(sdi_pkg::CMD_RESP), 1'b0);
    send(rand_req(sdi_pkg::CMD_BLOCK), 1'b0);
    send(info_req(3'd7), 1'b1);
    // A card that answers CMD8 with an error ends bring-up at once.
    bring_up(IFC_BROKEN, 1'b1, 1'b1, 0, 1'b0, 1'b1, ok);
    // Full bring-up of a high capacity card with all-ones words, then a
    // write to the last block and info reads of the stored words.
    word_style = WS_ONES;
    bring_up(IFC_V2, 1'b1, 1'b1, 0, 1'b1, 1'b1, ok);
    block_access(32'hFFFF_FFFF, 1'b1, 1);
    send(info_req(3'd0), 1'b1);
    send(info_req(3'd7), 1'b1);
    ready_now = ok;
    word_style = WS_RANDOM;

    // Random part, in three stretches of different idling.
    noise_on  = 1'b1;
    abort_pct = 3;
    random_phase(390);
    drain_all();
    tx_idle_pct = 45;
    rx_idle_pct = 35;
    random_phase(760);
    drain_all();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_phase(1130);
    drain_all();

    // One result per item, each registered in the cycle after its request is taken:
    // the closing wait catches anything extra.
    repeat (8) @(negedge clk);
    if (cmd_expect_q.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", cmd_expect_q.size()));
    end
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: the slowest correct run is far shorter than this.
  initial begin : watchdog
    #1000000;
    $display("tb: failure");
    $finish;
  end

endmodule
